FILE: src/y86_pkg.sv
// Package for the Y86-64 execute/memory/writeback unit: codes, widths, helpers.
package y86_pkg;

	localparam int MemBytes = 4096;
	localparam int MemAw = $clog2(MemBytes);
	localparam int RegCount = 15;
	localparam int RegAw = 4;
	localparam logic [3:0] SpIndex = 4'd4;
	localparam logic [RegAw-1:0] RegNone = 4'd15;

	typedef enum logic [1:0] {
		ST_AOK = 2'd0,
		ST_HLT = 2'd1,
		ST_ADR = 2'd2,
		ST_INS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		K_EXEC  = 2'd0,
		K_WRMEM = 2'd1,
		K_RDMEM = 2'd2,
		K_RDREG = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		I_HALT = 4'd0, I_NOP = 4'd1, I_CMOV = 4'd2, I_IRMOV = 4'd3,
		I_RMMOV = 4'd4, I_MRMOV = 4'd5, I_OP = 4'd6, I_JXX = 4'd7,
		I_CALL = 4'd8, I_RET = 4'd9, I_PUSH = 4'd10, I_POP = 4'd11,
		I_BAD12 = 4'd12, I_BAD13 = 4'd13, I_TRAP = 4'd14, I_BAD15 = 4'd15
	} icode_t;

	localparam logic [3:0] AluAdd = 4'd0;
	localparam logic [3:0] AluSub = 4'd1;
	localparam logic [3:0] AluAnd = 4'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  icode;
		logic [3:0]  ifun;
		logic [3:0]  reg_a;
		logic [3:0]  reg_b;
		logic [63:0] const_word;
		logic [63:0] next_pc;
		logic [11:0] mem_address;
		logic [7:0]  mem_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] pc;
		logic        cond;
		logic [63:0] read_data;
	} result_t;

	function automatic logic eval_cond(input logic [3:0] fn, input logic zf,
			input logic sf, input logic of_f);
		logic lt;
		lt = sf ^ of_f;
		case (fn)
			4'd0: eval_cond = 1'b1;
			4'd1: eval_cond = lt | zf;
			4'd2: eval_cond = lt;
			4'd3: eval_cond = zf;
			4'd4: eval_cond = ~zf;
			4'd5: eval_cond = ~lt;
			4'd6: eval_cond = ~lt & ~zf;
			default: eval_cond = 1'b0;
		endcase
	endfunction

	// 8-byte access fits when a <= MemBytes-8
	function automatic logic addr_ok(input logic [63:0] a);
		addr_ok = a <= 64'(MemBytes - 8);
	endfunction

endpackage

FILE: src/y86_execute_memory_writeback_unit.sv
// Top level: sequencer executing one decoded Y86-64 instruction per request.
// Preload, readback, invalid or ignored requests end after the register read; other
// instructions add operand read, execute and writeback; an address error ends after
// execute; loads and stores add eight byte accesses and popq a second writeback.
// Throughput: one request in flight; the next is accepted the cycle after the result.
// Reset: arst_n clears registers (via valid bits), pc, status and flags; dmem not cleared.
module y86_execute_memory_writeback_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: icode[3:0], ifun[7:4], reg_a[11:8], reg_b[15:12], const_word[79:16],
	// next_pc[143:80], mem_address[155:144], mem_byte[163:156], zero pad
	input  logic [167:0] s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,   // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: status[1:0], pc[65:2], cond[66], read_data[130:67], zero pad
	output logic [135:0] m_axis_tdata
);
	import y86_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RDA   = 9'b000000010,
		S_RDB   = 9'b000000100,
		S_EXEC  = 9'b000001000,
		S_MEM   = 9'b000010000,
		S_MWAIT = 9'b000100000,
		S_WB    = 9'b001000000,
		S_WB2   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q;
	item_t it_q;
	logic [63:0] a_q, b_q, e_q, ld_q, pc_q;
	status_t st_q;
	logic zf_q, sf_q, of_q, cnd_q;
	logic [63:0] rd_q;
	logic [3:0] bcnt_q;
	logic ld_bytes_q; // a load is in flight
	logic store_q;
	logic [63:0] store_val_q;

	logic [RegAw-1:0] rf_raddr, rf_waddr;
	logic [63:0] rf_rdata, rf_wdata;
	logic rf_we;

	y86_regfile u_rf (
		.clk(clk), .arst_n(arst_n), .raddr(rf_raddr), .rdata(rf_rdata),
		.we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata)
	);

	// data memory
	logic [7:0] dmem [MemBytes];
	logic [7:0] dmem_q;
	logic dm_we;
	logic [MemAw-1:0] dm_addr;
	logic [7:0] dm_wdata;
	always_ff @(posedge clk) begin
		if (dm_we) dmem[dm_addr] <= dm_wdata;
		dmem_q <= dmem[dm_addr];
	end

	// decode of held request
	logic ra_bad, rb_bad, uses_sp, illegal;
	logic [3:0] first_reg;
	always_comb begin
		ra_bad = it_q.reg_a == RegNone;
		rb_bad = it_q.reg_b == RegNone;
		uses_sp = it_q.icode inside {I_CALL, I_RET, I_PUSH, I_POP};
		case (it_q.icode)
			I_HALT, I_NOP, I_CALL, I_RET: illegal = 1'b0;
			I_CMOV: illegal = it_q.ifun > 4'd6 || ra_bad || rb_bad;
			I_IRMOV: illegal = rb_bad;
			I_RMMOV, I_MRMOV: illegal = ra_bad || rb_bad;
			I_OP: illegal = it_q.ifun > 4'd3 || ra_bad || rb_bad;
			I_JXX: illegal = it_q.ifun > 4'd6;
			I_PUSH, I_POP: illegal = ra_bad;
			I_TRAP: illegal = it_q.ifun > 4'd5;
			default: illegal = 1'b1;
		endcase
		first_reg = it_q.reg_a;
	end

	// execute stage combinational
	logic [63:0] alu_e, addr_e;
	logic alu_of, cond_c;
	always_comb begin
		alu_of = 1'b0;
		case (it_q.ifun)
			AluAdd: begin
				alu_e = b_q + a_q;
				alu_of = (~(a_q[63] ^ b_q[63])) & (a_q[63] ^ alu_e[63]);
			end
			AluSub: begin
				alu_e = b_q - a_q;
				alu_of = (a_q[63] ^ b_q[63]) & (b_q[63] ^ alu_e[63]);
			end
			AluAnd: alu_e = b_q & a_q;
			default: alu_e = b_q ^ a_q;
		endcase
		cond_c = eval_cond(it_q.ifun, zf_q, sf_q, of_q);
		case (it_q.icode)
			I_CALL, I_PUSH: addr_e = b_q - 64'd8;
			I_RET, I_POP: addr_e = b_q;
			default: addr_e = b_q + it_q.const_word;
		endcase
	end

	item_t in_item;
	assign in_item = '{kind: s_axis_tuser, icode: s_axis_tdata[3:0],
		ifun: s_axis_tdata[7:4], reg_a: s_axis_tdata[11:8],
		reg_b: s_axis_tdata[15:12], const_word: s_axis_tdata[79:16],
		next_pc: s_axis_tdata[143:80], mem_address: s_axis_tdata[155:144],
		mem_byte: s_axis_tdata[163:156]};

	assign s_axis_tready = state_q == S_IDLE;
	logic accept;
	assign accept = s_axis_tvalid && s_axis_tready;

	// memory port, register read address and register write selection
	always_comb begin
		dm_we = 1'b0;
		dm_addr = e_q[MemAw-1:0] + MemAw'(bcnt_q[2:0]);
		dm_wdata = store_val_q[8*bcnt_q[2:0] +: 8];
		rf_raddr = first_reg;
		rf_we = 1'b0;
		rf_waddr = it_q.reg_b;
		rf_wdata = e_q;
		if (accept) begin
			dm_addr = in_item.mem_address[MemAw-1:0];
			dm_we = in_item.kind == K_WRMEM;
			dm_wdata = in_item.mem_byte;
			rf_raddr = in_item.reg_a;
		end else if (state_q == S_RDA) begin
			rf_raddr = uses_sp ? SpIndex : it_q.reg_b;
		end else if (state_q == S_MEM) begin
			dm_we = store_q;
		end
		if (state_q == S_WB) begin
			rf_we = 1'b1;
			case (it_q.icode)
				I_CMOV: begin rf_we = cnd_q; rf_waddr = it_q.reg_b; rf_wdata = a_q; end
				I_IRMOV: begin rf_waddr = it_q.reg_b; rf_wdata = it_q.const_word; end
				I_OP: begin rf_waddr = it_q.reg_b; rf_wdata = e_q; end
				I_MRMOV: begin rf_waddr = it_q.reg_a; rf_wdata = ld_q; end
				I_CALL, I_PUSH: begin rf_waddr = SpIndex; rf_wdata = e_q; end
				I_RET, I_POP: begin rf_waddr = SpIndex; rf_wdata = e_q + 64'd8; end
				default: rf_we = 1'b0;
			endcase
		end else if (state_q == S_WB2) begin
			rf_we = 1'b1;
			rf_waddr = it_q.reg_a;
			rf_wdata = ld_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= ST_AOK;
			pc_q <= '0;
			zf_q <= 1'b0;
			sf_q <= 1'b0;
			of_q <= 1'b0;
			bcnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (accept) begin
					it_q <= in_item;
					cnd_q <= 1'b0;
					rd_q <= '0;
					state_q <= S_RDA;
				end
				S_RDA: begin
					// kinds other than execute finish with their read data now
					case (it_q.kind)
						K_RDMEM: begin rd_q <= {56'd0, dmem_q}; state_q <= S_OUT; end
						K_RDREG: begin rd_q <= rf_rdata; state_q <= S_OUT; end
						K_WRMEM: state_q <= S_OUT;
						default: begin
							a_q <= rf_rdata;
							if (st_q != ST_AOK) state_q <= S_OUT;
							else if (illegal) begin
								st_q <= ST_INS;
								state_q <= S_OUT;
							end else state_q <= S_RDB;
						end
					endcase
				end
				S_RDB: begin
					b_q <= rf_rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					e_q <= it_q.icode == I_OP ? alu_e : addr_e;
					bcnt_q <= '0;
					ld_bytes_q <= it_q.icode inside {I_MRMOV, I_RET, I_POP};
					store_q <= it_q.icode inside {I_RMMOV, I_CALL, I_PUSH};
					store_val_q <= it_q.icode == I_CALL ? it_q.next_pc : a_q;
					pc_q <= it_q.next_pc;
					state_q <= S_WB;
					case (it_q.icode)
						I_HALT: st_q <= ST_HLT;
						I_CMOV: cnd_q <= cond_c;
						I_OP: begin
							zf_q <= alu_e == 64'd0;
							sf_q <= alu_e[63];
							of_q <= alu_of;
						end
						I_JXX: begin
							cnd_q <= cond_c;
							pc_q <= cond_c ? it_q.const_word : it_q.next_pc;
						end
						I_RMMOV, I_MRMOV, I_CALL, I_RET, I_PUSH, I_POP: begin
							if (!addr_ok(addr_e)) begin
								st_q <= ST_ADR;
								if (it_q.icode == I_RMMOV) pc_q <= pc_q;
								state_q <= S_OUT;
							end else state_q <= S_MEM;
						end
						default: ;
					endcase
				end
				S_MEM: begin
					// one byte is accessed here; the registered load byte is taken in S_MWAIT
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (ld_bytes_q) ld_q[8*bcnt_q[2:0] +: 8] <= dmem_q;
					if (bcnt_q == 4'd7) begin
						state_q <= S_WB;
					end else begin
						bcnt_q <= bcnt_q + 4'd1;
						state_q <= S_MEM;
					end
				end
				S_WB: begin
					if (it_q.icode == I_CALL) pc_q <= it_q.const_word;
					if (it_q.icode == I_RET) pc_q <= ld_q;
					state_q <= it_q.icode == I_POP ? S_WB2 : S_OUT;
				end
				S_WB2: state_q <= S_OUT;
				S_OUT: if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	result_t res;
	assign res = '{status: st_q, pc: pc_q, cond: cnd_q, read_data: rd_q};
	assign m_axis_tvalid = state_q == S_OUT;
	assign m_axis_tdata = {5'd0, res.read_data, res.cond, res.pc, res.status};

	// status never returns to AOK except through reset
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(st_q) != ST_AOK |-> st_q == $past(st_q))
		else $error("status left a terminal state");
	// register writes only happen in writeback states
	assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> (state_q == S_WB || state_q == S_WB2))
		else $error("register write outside writeback");
	// memory writes only on preload accept or store cycles
	assert property (@(posedge clk) disable iff (!arst_n)
		dm_we |-> (accept || (state_q == S_MEM && store_q)))
		else $error("unexpected memory write");
endmodule

FILE: src/y86_regfile.sv
// Register file: 15 x 64-bit synchronous memory, one read port, one write port.
module y86_regfile (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [y86_pkg::RegAw-1:0] raddr,
	output logic [63:0]              rdata,
	input  logic                     we,
	input  logic [y86_pkg::RegAw-1:0] waddr,
	input  logic [63:0]              wdata
);
	import y86_pkg::*;

	logic [63:0] mem [RegCount];
	logic [RegCount-1:0] valid_q;
	logic [63:0] rdata_q;
	logic rvalid_q;

	// registers read as zero until first written after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we && waddr != RegNone) valid_q[waddr] <= 1'b1;
			rvalid_q <= (raddr != RegNone) && valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we && waddr != RegNone) mem[waddr] <= wdata;
		rdata_q <= mem[(raddr == RegNone) ? '0 : raddr];
	end

	assign rdata = rvalid_q ? rdata_q : 64'd0;
endmodule

FILE: sim/y86_execute_memory_writeback_unit_tb.sv
// Testbench for the Y86-64 execute/memory/writeback unit: random programs checked against a predictor.
`timescale 1ns / 1ps

module y86_execute_memory_writeback_unit_tb;
	import y86_pkg::*;

	localparam logic [3:0] AluXor = 4'd3;
	localparam logic [3:0] CondAlways = 4'd0;
	localparam logic [3:0] CondLe = 4'd1;
	localparam logic [3:0] CondL = 4'd2;
	localparam logic [3:0] CondE = 4'd3;
	localparam logic [3:0] CondNe = 4'd4;
	localparam logic [3:0] CondGe = 4'd5;
	localparam logic [3:0] CondG = 4'd6;
	localparam logic [63:0] TopWord = 64'(MemBytes - 8);
	localparam int IdleLimit = 3000;
	localparam int HoldCycles = 400;
	localparam int RandomItems = 1900;

	class y86_arch_scoreboard;
		logic [63:0] regs[RegCount];
		logic [7:0] mem[MemBytes];
		bit written[MemBytes];
		logic [63:0] pc;
		status_t st;
		bit zf, sf, ovf;
		result_t arch_results[$];
		int errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (written[i]) written[i] = 0;
			pc = '0;
			st = ST_AOK;
			zf = 0;
			sf = 0;
			ovf = 0;
			errors = 0;
		endfunction

		function logic [63:0] load_word(logic [63:0] a);
			logic [63:0] v;
			v = '0;
			for (int i = 0; i < 8; i++) v[8*i +: 8] = mem[a + i];
			return v;
		endfunction

		function void store_word(logic [63:0] a, logic [63:0] v);
			for (int i = 0; i < 8; i++) begin
				mem[a + i] = v[8*i +: 8];
				written[a + i] = 1;
			end
		endfunction

		function bit cond_holds(logic [3:0] fn);
			bit lt;
			lt = sf ^ ovf;
			case (fn)
				CondAlways: return 1;
				CondLe: return lt | zf;
				CondL: return lt;
				CondE: return zf;
				CondNe: return !zf;
				CondGe: return !lt;
				CondG: return !lt && !zf;
				default: return 0;
			endcase
		endfunction

		// address of the 8-byte load this instruction would do, or -1
		function longint load_addr(item_t it);
			logic [63:0] e;
			if (st != ST_AOK) return -1;
			case (icode_t'(it.icode))
				I_MRMOV: begin
					e = regs[it.reg_b] + it.const_word;
					if (it.reg_a != RegNone && it.reg_b != RegNone && e <= TopWord) return e;
				end
				I_RET: if (regs[SpIndex] <= TopWord) return regs[SpIndex];
				I_POP: if (it.reg_a != RegNone && regs[SpIndex] <= TopWord) return regs[SpIndex];
				default: ;
			endcase
			return -1;
		endfunction

		function bit run_instr(item_t it);
			logic [3:0] fn, ra, rb;
			logic [63:0] a, b, e, sp, vc, vp;
			bit ra_bad, rb_bad, c;
			fn = it.ifun;
			ra = it.reg_a;
			rb = it.reg_b;
			vc = it.const_word;
			vp = it.next_pc;
			ra_bad = ra == RegNone;
			rb_bad = rb == RegNone;
			c = 0;
			case (icode_t'(it.icode))
				I_HALT: begin
					st = ST_HLT;
					pc = vp;
				end
				I_NOP: pc = vp;
				I_CMOV: begin
					if (fn > CondG || ra_bad || rb_bad) st = ST_INS;
					else begin
						c = cond_holds(fn);
						if (c) regs[rb] = regs[ra];
						pc = vp;
					end
				end
				I_IRMOV: begin
					if (rb_bad) st = ST_INS;
					else begin
						regs[rb] = vc;
						pc = vp;
					end
				end
				I_RMMOV: begin
					e = regs[rb] + vc;
					if (ra_bad || rb_bad) st = ST_INS;
					else if (e > TopWord) st = ST_ADR;
					else begin
						store_word(e, regs[ra]);
						pc = vp;
					end
				end
				I_MRMOV: begin
					e = regs[rb] + vc;
					if (ra_bad || rb_bad) st = ST_INS;
					else begin
						if (e > TopWord) st = ST_ADR;
						else regs[ra] = load_word(e);
						pc = vp;
					end
				end
				I_OP: begin
					if (fn > AluXor || ra_bad || rb_bad) st = ST_INS;
					else begin
						a = regs[ra];
						b = regs[rb];
						ovf = 0;
						case (fn)
							AluAdd: begin
								e = b + a;
								ovf = ~(a[63] ^ b[63]) & (a[63] ^ e[63]);
							end
							AluSub: begin
								e = b - a;
								ovf = (a[63] ^ b[63]) & (b[63] ^ e[63]);
							end
							AluAnd: e = b & a;
							default: e = b ^ a;
						endcase
						zf = e == 0;
						sf = e[63];
						regs[rb] = e;
						pc = vp;
					end
				end
				I_JXX: begin
					if (fn > CondG) st = ST_INS;
					else begin
						c = cond_holds(fn);
						pc = c ? vc : vp;
					end
				end
				I_CALL: begin
					e = regs[SpIndex] - 64'd8;
					if (e > TopWord) begin
						st = ST_ADR;
						pc = vp;
					end else begin
						store_word(e, vp);
						regs[SpIndex] = e;
						pc = vc;
					end
				end
				I_RET: begin
					sp = regs[SpIndex];
					if (sp > TopWord) begin
						st = ST_ADR;
						pc = vp;
					end else begin
						pc = load_word(sp);
						regs[SpIndex] = sp + 64'd8;
					end
				end
				I_PUSH: begin
					if (ra_bad) st = ST_INS;
					else begin
						a = regs[ra];
						e = regs[SpIndex] - 64'd8;
						if (e > TopWord) st = ST_ADR;
						else begin
							store_word(e, a);
							regs[SpIndex] = e;
						end
						pc = vp;
					end
				end
				I_POP: begin
					if (ra_bad) st = ST_INS;
					else begin
						sp = regs[SpIndex];
						if (sp > TopWord) st = ST_ADR;
						else begin
							a = load_word(sp);
							regs[SpIndex] = sp + 64'd8;
							regs[ra] = a;
						end
						pc = vp;
					end
				end
				I_TRAP: begin
					if (fn > 4'd5) st = ST_INS;
					else pc = vp;
				end
				default: st = ST_INS;
			endcase
			return c;
		endfunction

		function void note_request(kind_t k, item_t it);
			result_t r;
			r.cond = 0;
			r.read_data = '0;
			case (k)
				K_EXEC: if (st == ST_AOK) r.cond = run_instr(it);
				K_WRMEM: begin
					mem[it.mem_address] = it.mem_byte;
					written[it.mem_address] = 1;
				end
				K_RDMEM: r.read_data = {56'd0, mem[it.mem_address]};
				default: if (it.reg_a != RegNone) r.read_data = regs[it.reg_a];
			endcase
			r.status = st;
			r.pc = pc;
			arch_results.push_back(r);
		endfunction

		function void check_result(logic [135:0] d);
			result_t x;
			if (arch_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, d);
				errors++;
				return;
			end
			x = arch_results.pop_front();
			if (d[1:0] !== x.status) begin
				$display("%0t: status expected %0d actual %0d", $time, x.status, d[1:0]);
				errors++;
			end
			if (d[65:2] !== x.pc) begin
				$display("%0t: pc expected %h actual %h", $time, x.pc, d[65:2]);
				errors++;
			end
			if (d[66] !== x.cond) begin
				$display("%0t: cond expected %b actual %b", $time, x.cond, d[66]);
				errors++;
			end
			if (d[130:67] !== x.read_data) begin
				$display("%0t: read_data expected %h actual %h", $time, x.read_data, d[130:67]);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [167:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [135:0] m_axis_tdata;

	y86_execute_memory_writeback_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	y86_arch_scoreboard sb = new();
	int burst_left = 0;
	int sent_items = 0;
	bit hold_req = 0;
	int hold_cnt = 0;
	logic [15:0] ready_pattern = '1;
	int pattern_age = 0;
	int idle_cycles = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic item_t instr(icode_t ic, logic [3:0] fn, logic [3:0] ra, logic [3:0] rb,
			logic [63:0] vc);
		item_t it;
		it.kind = K_EXEC;
		it.icode = ic;
		it.ifun = fn;
		it.reg_a = ra;
		it.reg_b = rb;
		it.const_word = vc;
		it.next_pc = rand64();
		it.mem_address = 12'($urandom);
		it.mem_byte = 8'($urandom);
		return it;
	endfunction

	task automatic drive(kind_t k, item_t it);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tdata <= {4'd0, it.mem_byte, it.mem_address, it.next_pc, it.const_word,
			it.reg_b, it.reg_a, it.ifun, it.icode};
		s_axis_tuser <= k;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(k, it);
		burst_left--;
		sent_items++;
	endtask

	// fills never-written bytes before any request that would read them
	task automatic send(kind_t k, item_t it);
		item_t wr;
		longint a;
		wr = it;
		wr.mem_byte = 8'($urandom);
		a = (k == K_EXEC) ? sb.load_addr(it) : -1;
		if (a >= 0) begin
			for (int i = 0; i < 8; i++) begin
				if (!sb.written[a + i]) begin
					wr.mem_address = 12'(a + i);
					wr.mem_byte = 8'($urandom);
					drive(K_WRMEM, wr);
				end
			end
		end
		if (k == K_RDMEM && !sb.written[it.mem_address]) begin
			wr.mem_address = it.mem_address;
			drive(K_WRMEM, wr);
		end
		it.kind = k;
		drive(k, it);
	endtask

	function automatic logic [63:0] to_addr(logic [3:0] rb, logic [63:0] target);
		return target - sb.regs[rb];
	endfunction

	// well-formed instruction that keeps the machine running
	function automatic item_t rand_instr();
		item_t it;
		logic [63:0] sp;
		icode_t ic;
		logic [3:0] rb;
		sp = sb.regs[SpIndex];
		rb = 4'($urandom_range(0, 14));
		case ($urandom_range(0, 11))
			0: ic = I_NOP;
			1: ic = I_CMOV;
			2: ic = I_IRMOV;
			3: ic = I_RMMOV;
			4: ic = I_MRMOV;
			5: ic = I_OP;
			6: ic = I_JXX;
			7: ic = I_CALL;
			8: ic = I_RET;
			9: ic = I_PUSH;
			10: ic = I_POP;
			default: ic = I_TRAP;
		endcase
		it = instr(ic, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 14)), rb,
			$urandom_range(0, 3) == 0 ? 64'($urandom_range(0, 3)) : rand64());
		case (ic)
			I_CMOV, I_JXX: it.ifun = 4'($urandom_range(0, 6));
			I_OP: it.ifun = 4'($urandom_range(0, 3));
			I_TRAP: it.ifun = 4'($urandom_range(0, 5));
			I_IRMOV: it.reg_a = 4'($urandom_range(0, 15));
			I_RMMOV, I_MRMOV:
				it.const_word = to_addr(rb, 64'($urandom_range(0, MemBytes - 8)));
			I_POP: it.reg_b = 4'($urandom_range(0, 15));
			I_PUSH: it.reg_b = 4'($urandom_range(0, 15));
			default: ;
		endcase
		if (((ic == I_CALL || ic == I_PUSH) && (sp < 8 || sp > MemBytes))
				|| ((ic == I_RET || ic == I_POP) && sp > TopWord))
			it = instr(I_IRMOV, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), SpIndex,
				64'($urandom_range(1, MemBytes / 8 - 1) * 8));
		return it;
	endfunction

	task automatic send_random();
		item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it = rand_instr();
		it.reg_a = (pick >= 94) ? 4'($urandom_range(0, 15)) : it.reg_a;
		if (pick < 80) send(K_EXEC, it);
		else if (pick < 87) send(K_WRMEM, it);
		else if (pick < 94) send(K_RDMEM, it);
		else send(K_RDREG, it);
	endtask

	// one fault or halt; the machine stays stopped afterwards
	task automatic send_stop();
		item_t it;
		it = instr(I_NOP, 0, 4'($urandom_range(0, 14)), 4'($urandom_range(0, 14)), rand64());
		case ($urandom_range(0, 11))
			0: it.icode = I_HALT;
			1: it.icode = I_BAD12;
			2: it.icode = I_BAD13;
			3: it.icode = I_BAD15;
			4: begin
				it.icode = I_OP;
				it.ifun = 4'($urandom_range(4, 15));
			end
			5: begin
				it.icode = I_CMOV;
				it.reg_a = RegNone;
			end
			6: begin
				it.icode = I_JXX;
				it.ifun = 4'($urandom_range(7, 15));
			end
			7: begin
				it.icode = I_TRAP;
				it.ifun = 4'($urandom_range(6, 15));
			end
			8: begin
				it.icode = I_RMMOV;
				it.const_word = to_addr(it.reg_b, TopWord + 64'($urandom_range(1, 5000)));
			end
			9: begin
				it.icode = I_MRMOV;
				it.const_word = to_addr(it.reg_b, 64'hFFFF_FFFF_FFFF_FFF8);
			end
			10: begin
				send(K_EXEC, instr(I_IRMOV, 0, RegNone, SpIndex, 64'(MemBytes)));
				it.icode = I_RET;
			end
			default: begin
				send(K_EXEC, instr(I_IRMOV, 0, RegNone, SpIndex, 64'd0));
				it.icode = $urandom_range(0, 1) ? I_CALL : I_PUSH;
			end
		endcase
		send(K_EXEC, it);
	endtask

	initial begin
		item_t it;
		bit hold_done;
		bit pause_done;
		hold_done = 0;
		pause_done = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = K_EXEC;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		it = instr(I_NOP, 0, RegNone, RegNone, 0);
		send(K_RDREG, it);
		send(K_EXEC, instr(I_IRMOV, 0, RegNone, 0, '1));
		send(K_EXEC, instr(I_IRMOV, 0, RegNone, 1, 64'h8000_0000_0000_0000));
		send(K_EXEC, instr(I_IRMOV, 0, RegNone, 2, 64'h7FFF_FFFF_FFFF_FFFF));
		send(K_EXEC, instr(I_OP, AluAdd, 2, 2, 0));
		send(K_EXEC, instr(I_JXX, CondL, 0, 0, rand64()));
		send(K_EXEC, instr(I_OP, AluSub, 0, 1, 0));
		send(K_EXEC, instr(I_CMOV, CondLe, 1, 3, 0));
		send(K_EXEC, instr(I_OP, AluXor, 3, 3, 0));
		send(K_EXEC, instr(I_CMOV, CondE, 0, 5, 0));
		send(K_EXEC, instr(I_JXX, CondG, 0, 0, rand64()));
		send(K_EXEC, instr(I_OP, AluAnd, 0, 1, 0));
		send(K_EXEC, instr(I_CMOV, CondGe, 0, 6, 0));
		send(K_EXEC, instr(I_JXX, CondNe, 0, 0, rand64()));
		send(K_EXEC, instr(I_IRMOV, 0, RegNone, SpIndex, TopWord));
		send(K_EXEC, instr(I_PUSH, 0, SpIndex, RegNone, 0));
		send(K_EXEC, instr(I_POP, 0, SpIndex, RegNone, 0));
		send(K_EXEC, instr(I_CALL, 0, RegNone, RegNone, rand64()));
		send(K_EXEC, instr(I_RET, 0, RegNone, RegNone, 0));
		send(K_EXEC, instr(I_RMMOV, 0, 0, 1, to_addr(1, TopWord)));
		send(K_EXEC, instr(I_MRMOV, 0, 14, 2, to_addr(2, 0)));
		send(K_EXEC, instr(I_TRAP, 4'd5, 0, 0, 0));
		it.mem_address = '1;
		it.mem_byte = '1;
		send(K_WRMEM, it);
		send(K_RDMEM, it);
		send(K_RDREG, instr(I_NOP, 0, 14, 0, 0));

		// count includes the preload writes that send() adds
		while (sent_items < RandomItems) begin
			if (!hold_done && sent_items >= 600) begin
				hold_done = 1;
				hold_req = 1;
			end
			if (!pause_done && sent_items >= 1200) begin
				pause_done = 1;
				s_axis_tvalid <= 1'b0;
				burst_left = 0;
				while (sb.arch_results.size() != 0) @(posedge clk);
			end
			send_random();
		end
		send_stop();
		for (int n = 0; n < 25; n++) send_random();

		s_axis_tvalid <= 1'b0;
		while (sb.arch_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// receiver: rotating stall pattern, full-rate windows, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = HoldCycles;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ready_pattern[pattern_age % 16];
				pattern_age++;
				if (pattern_age == 64) begin
					pattern_age = 0;
					ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("%0t: timeout", $time);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule
